// ----- hw/rtl/tmt_pkg.sv -----
// Shared constants, codes and types for the timestamp merge tournament tree.
`default_nettype none
package tmt_pkg;
  localparam int LEAVES          = 16;
  localparam int VIRTUAL_SOURCES = 8;
  localparam int RING_DEPTH      = 64;
  localparam int NODES           = 2 * LEAVES + 1;
  localparam int LEAF_W          = $clog2(LEAVES);
  localparam int NODE_W          = $clog2(NODES);
  localparam int VS_W            = (VIRTUAL_SOURCES > 1) ? $clog2(VIRTUAL_SOURCES) : 1;
  localparam int PTR_W           = $clog2(RING_DEPTH);
  localparam int RING_WORDS      = VIRTUAL_SOURCES * RING_DEPTH;
  localparam int RADDR_W         = $clog2(RING_WORDS);
  localparam int IN_W            = 80;
  localparam int OUT_W           = 88;

  localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  ID_NONE  = 8'hFF;

  localparam logic [1:0] MODE_PUT  = 2'd0;
  localparam logic [1:0] MODE_NEXT = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CLEARED  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam logic CFG_OFFSET = 1'b0;
  localparam logic CFG_REAL   = 1'b1;

  typedef enum logic [1:0] {ACT_NONE, ACT_SET, ACT_FETCH} act_e;

  typedef struct packed {
    logic [63:0] tstamp;
    logic [7:0]  src;
    logic [7:0]  chn;
  } node_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic fetch;
    logic set_leaf;
    logic walk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic at_root;
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/timestamp_merge_tournament_tree.sv -----
// Top level: timestamp merge tournament tree with stream ports and config write port.
// Steps: accept, then decode; ops that leave the tree alone go straight on to the result.
// Otherwise ring fetch (next with refill), leaf write and a tree walk up to the root come first.
// One transaction at a time; next accept in the cycle the result is shown if it is taken.
// The tree walk (one level per cycle over the node memory) sets the rate.
// Asynchronous active-low reset; tree, pointers and config clear at once, no clearing pass.
`default_nettype none
module timestamp_merge_tournament_tree (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire [tmt_pkg::IN_W-1:0]    s_axis_tdata,  // mode, timestamp, channel, source_index
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [tmt_pkg::OUT_W-1:0]  m_axis_tdata,  // out_time, out_source, out_channel, status
  input  wire                        cfg_we_i,
  input  wire                        cfg_index_i,
  input  wire [7:0]                  cfg_data_i
);
  tmt_pkg::cmd_t     cmd;
  tmt_pkg::dp_stat_t stat;

  tmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tmt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/tmt_datapath.sv -----
// Datapath: tree node memory, ring memory, ring pointers, leaf walk and result register.
`default_nettype none
module tmt_datapath (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire                      cfg_index_i,
  input  wire [7:0]                cfg_data_i,
  input  wire [tmt_pkg::IN_W-1:0]  in_data_i,
  input  wire tmt_pkg::cmd_t       cmd_i,
  output tmt_pkg::dp_stat_t        stat_o,
  output logic [tmt_pkg::OUT_W-1:0] out_data_o
);
  localparam int LW = tmt_pkg::LEAF_W;
  localparam int NW = tmt_pkg::NODE_W;
  localparam int VW = tmt_pkg::VS_W;
  localparam int PW = tmt_pkg::PTR_W;
  localparam int AW = tmt_pkg::RADDR_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (int'(p) == tmt_pkg::RING_DEPTH - 1) ? '0 : PW'(int'(p) + 1);
  endfunction

  function automatic logic [NW-1:0] sibling(input logic [NW-1:0] i);
    if (i == '0) sibling = '0;
    else if (i[0]) sibling = NW'(int'(i) + 1);
    else sibling = NW'(int'(i) - 1);
  endfunction

  function automatic logic [AW-1:0] ring_addr(input logic [VW-1:0] v, input logic [PW-1:0] p);
    ring_addr = AW'(int'(v) * tmt_pkg::RING_DEPTH + int'(p));
  endfunction

  logic [7:0]          offset_q;
  logic [4:0]          real_q;
  logic [1:0]          mode_q;
  logic [63:0]         time_q;
  logic [7:0]          chn_q;
  logic [3:0]          idx_q;
  tmt_pkg::node_t      root_q, snap_q, cur_q;
  logic [LW-1:0]       leaf_q;
  logic [NW-1:0]       node_q;
  logic [1:0]          status_q;
  logic [PW-1:0]       head_q [tmt_pkg::VIRTUAL_SOURCES];
  logic [PW-1:0]       tail_q [tmt_pkg::VIRTUAL_SOURCES];
  logic [tmt_pkg::LEAVES-1:0] idle_q;
  logic [tmt_pkg::NODES-1:0]  nvalid_q;
  tmt_pkg::node_t      node_mem [tmt_pkg::NODES];
  logic [63:0]         ring_mem [tmt_pkg::RING_WORDS];
  tmt_pkg::node_t      nrd_q;
  logic [NW-1:0]       nrd_addr_q;
  logic                nrd_valid_q;
  logic [63:0]         rrd_q;

  // decode
  logic [9:0]     diff, lsum;
  logic           put_ok, next_ok, set_ok;
  logic [VW-1:0]  pvs, nvs;
  logic [LW-1:0]  pleaf;
  logic [7:0]     nvs8;
  logic           ring_full, ring_empty;
  tmt_pkg::act_e  act;
  logic [1:0]     dstatus;
  logic [AW-1:0]  ring_raddr;

  always_comb begin
    diff    = {2'b00, chn_q} - {2'b00, offset_q};
    lsum    = diff + {5'b0, real_q};
    put_ok  = !diff[9] && (int'(diff) < tmt_pkg::VIRTUAL_SOURCES) &&
              (int'(lsum) < tmt_pkg::LEAVES);
    pvs     = VW'(diff);
    pleaf   = LW'(lsum);
    nvs8    = snap_q.src - {3'b0, real_q};
    nvs     = VW'(nvs8);
    next_ok = (snap_q.tstamp != tmt_pkg::TIME_MAX) && (snap_q.src >= {3'b0, real_q}) &&
              (int'(nvs8) < tmt_pkg::VIRTUAL_SOURCES) &&
              (int'(snap_q.src) < tmt_pkg::LEAVES);
    set_ok  = int'(idx_q) < tmt_pkg::LEAVES;
    ring_full  = ptr_inc(head_q[pvs]) == tail_q[pvs];
    ring_empty = head_q[nvs] == tail_q[nvs];
    ring_raddr = ring_addr(nvs, tail_q[nvs]);
    act     = tmt_pkg::ACT_NONE;
    dstatus = tmt_pkg::ST_OK;
    unique case (mode_q)
      tmt_pkg::MODE_PUT: begin
        if (!put_ok) dstatus = tmt_pkg::ST_RANGE;
        else if (time_q == tmt_pkg::TIME_MAX) begin
          dstatus = tmt_pkg::ST_CLEARED;
          act = tmt_pkg::ACT_SET;
        end else if (idle_q[pleaf]) act = tmt_pkg::ACT_SET;
        else if (ring_full) dstatus = tmt_pkg::ST_OVERFLOW;
      end
      tmt_pkg::MODE_NEXT: begin
        if (next_ok) act = ring_empty ? tmt_pkg::ACT_SET : tmt_pkg::ACT_FETCH;
      end
      tmt_pkg::MODE_SET: begin
        if (set_ok) act = tmt_pkg::ACT_SET;
        else dstatus = tmt_pkg::ST_RANGE;
      end
      default: ;
    endcase
  end

  // walk
  tmt_pkg::node_t sib, winner, nwdata;
  logic [NW-1:0]  parent, leaf_node, nwaddr, nraddr;
  logic           nwe;

  always_comb begin
    sib = nrd_q;
    if (!nrd_valid_q) begin
      sib.tstamp = tmt_pkg::TIME_MAX;
      sib.chn    = tmt_pkg::ID_NONE;
      sib.src    = (int'(nrd_addr_q) >= tmt_pkg::LEAVES &&
                    int'(nrd_addr_q) < 2 * tmt_pkg::LEAVES) ?
                   8'(int'(nrd_addr_q) - tmt_pkg::LEAVES) : tmt_pkg::ID_NONE;
    end
    parent = NW'((int'(node_q) - 1) >> 1);
    if (node_q[0]) winner = ($signed(cur_q.tstamp) < $signed(sib.tstamp)) ? cur_q : sib;
    else winner = ($signed(sib.tstamp) < $signed(cur_q.tstamp)) ? sib : cur_q;
    leaf_node = NW'(int'(leaf_q) + tmt_pkg::LEAVES);
    nwe    = cmd_i.set_leaf || cmd_i.walk;
    nwaddr = cmd_i.set_leaf ? leaf_node : parent;
    nwdata = cmd_i.set_leaf ? cur_q : winner;
    nraddr = sibling(nwaddr);
  end

  assign stat_o = '{act: act, at_root: (parent == '0)};

  always_ff @(posedge clk_i) begin
    if (nwe) node_mem[nwaddr] <= nwdata;
    nrd_q      <= node_mem[nraddr];
    nrd_addr_q <= nraddr;
    rrd_q      <= ring_mem[ring_raddr];
    if (cmd_i.decode && mode_q == tmt_pkg::MODE_PUT && act == tmt_pkg::ACT_NONE &&
        dstatus == tmt_pkg::ST_OK) begin
      ring_mem[ring_addr(pvs, head_q[pvs])] <= time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      real_q      <= '0;
      nvalid_q    <= '0;
      nrd_valid_q <= 1'b0;
      idle_q      <= '1;
      root_q      <= '{tstamp: tmt_pkg::TIME_MAX, src: tmt_pkg::ID_NONE,
                       chn: tmt_pkg::ID_NONE};
      for (int v = 0; v < tmt_pkg::VIRTUAL_SOURCES; v++) begin
        head_q[v] <= '0;
        tail_q[v] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tmt_pkg::CFG_OFFSET: offset_q <= cfg_data_i;
          tmt_pkg::CFG_REAL:   real_q   <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      nrd_valid_q <= nvalid_q[nraddr];
      if (nwe) nvalid_q[nwaddr] <= 1'b1;
      if (cmd_i.set_leaf) idle_q[leaf_q] <= (cur_q.tstamp == tmt_pkg::TIME_MAX);
      if (cmd_i.walk && parent == '0) root_q <= winner;
      if (cmd_i.decode) begin
        if (mode_q == tmt_pkg::MODE_PUT && dstatus == tmt_pkg::ST_CLEARED) begin
          head_q[pvs] <= '0;
          tail_q[pvs] <= '0;
        end else if (mode_q == tmt_pkg::MODE_PUT && act == tmt_pkg::ACT_NONE &&
                     dstatus == tmt_pkg::ST_OK) begin
          head_q[pvs] <= ptr_inc(head_q[pvs]);
        end else if (act == tmt_pkg::ACT_FETCH) begin
          tail_q[nvs] <= ptr_inc(tail_q[nvs]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_data_i[1:0];
      time_q <= in_data_i[65:2];
      chn_q  <= in_data_i[73:66];
      idx_q  <= in_data_i[77:74];
      snap_q <= root_q;
    end
    if (cmd_i.decode) begin
      status_q <= dstatus;
      priority case (mode_q)
        tmt_pkg::MODE_PUT: begin
          leaf_q <= pleaf;
          cur_q  <= '{tstamp: time_q, src: 8'(pleaf), chn: chn_q};
        end
        tmt_pkg::MODE_NEXT: begin
          leaf_q <= LW'(snap_q.src);
          cur_q  <= '{tstamp: tmt_pkg::TIME_MAX, src: snap_q.src, chn: snap_q.chn};
        end
        default: begin
          leaf_q <= LW'(idx_q);
          cur_q  <= '{tstamp: time_q, src: 8'(idx_q), chn: chn_q};
        end
      endcase
    end
    if (cmd_i.fetch) cur_q.tstamp <= rrd_q;
    if (cmd_i.set_leaf) node_q <= leaf_node;
    if (cmd_i.walk) begin
      node_q <= parent;
      cur_q  <= winner;
    end
    if (cmd_i.emit) begin
      out_data_o <= (mode_q == tmt_pkg::MODE_NEXT) ?
                    {6'b0, status_q, snap_q.chn, snap_q.src, snap_q.tstamp} :
                    {6'b0, status_q, root_q.chn, root_q.src, root_q.tstamp};
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tmt_ctrl.sv -----
// Controller: sequences decode, ring fetch, leaf write and tree walk for each transaction.
`default_nettype none
module tmt_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  input  wire tmt_pkg::dp_stat_t stat_i,
  output tmt_pkg::cmd_t         cmd_o
);
  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_FETCH, S_SET, S_WALK, S_DONE} state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = in_valid_i && in_ready_o;
    cmd_o.decode   = state_q == S_DECODE;
    cmd_o.fetch    = state_q == S_FETCH;
    cmd_o.set_leaf = state_q == S_SET;
    cmd_o.walk     = state_q == S_WALK;
    cmd_o.emit     = state_q == S_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:   if (in_valid_i && in_ready_o) state_q <= S_DECODE;
        S_DECODE: begin
          unique case (stat_i.act)
            tmt_pkg::ACT_SET:   state_q <= S_SET;
            tmt_pkg::ACT_FETCH: state_q <= S_FETCH;
            default:            state_q <= S_DONE;
          endcase
        end
        S_FETCH:  state_q <= S_SET;
        S_SET:    state_q <= S_WALK;
        S_WALK:   if (stat_i.at_root) state_q <= S_DONE;
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tmt_checker.sv -----
// Port-level checker for the timestamp merge tournament tree, bound to the top level.
`default_nettype none
module tmt_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire s_axis_tvalid,
  input wire s_axis_tready,
  input wire m_axis_tvalid,
  input wire m_axis_tready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back to back accept");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready)) else $error("result without work");
endmodule

bind timestamp_merge_tournament_tree tmt_checker u_tmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
`default_nettype wire
